### design/separating_axis_overlap_test_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the separating-axis overlap test
// Concurrent checks clocked on i_clk, off while reset is held.
// ---------------------------------------------------------------------------
`ifndef SEPARATING_AXIS_OVERLAP_TEST_ASSERT_SVH
`define SEPARATING_AXIS_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication
`define SAOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/saot_pkg.sv
// ---------------------------------------------------------------------------
// saot_pkg
// Sizes, codes and types of the separating-axis overlap test.
// ---------------------------------------------------------------------------
`default_nettype none

package saot_pkg;

    localparam int MAX_CORNERS = 8;
    localparam int MAX_AXES    = 16;
    localparam int COORD_BITS  = 16;

    localparam int CIDX_W = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
    localparam int SEP_W  = 4;
    localparam int AXC_W  = 5;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int DOT_W  = 2 * COORD_BITS + 2;

    typedef enum logic [1:0] {
        KIND_CORNER_A = 2'd0,
        KIND_CORNER_B = 2'd1,
        KIND_AXIS     = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROJ  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_corner;

endpackage

`default_nettype wire

### design/separating_axis_overlap_test.sv
// ---------------------------------------------------------------------------
// separating_axis_overlap_test
// Separating-axis test of two convex corner sets, one dot product per cycle.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): each item is a corner of shape A,
// a corner of shape B, or a test axis. Up to 8 corners per shape are kept;
// more are dropped and flagged. For an axis item that must be projected,
// the stored corners of A, then of B, are streamed one per cycle through a
// single 3-multiplier dot-product unit followed by a min/max stage; the
// interval compare follows the drain. An axis that needs no projection
// (already separated, empty shape, or past 16 axes) is not projected.
// o_in_ready is low while an axis is in work.
// Output channel (o_out_valid / i_out_ready): an axis item marked last gives
// one result item, registered, and clears the test. The input side keeps
// taking items while a result waits; only a further last axis stalls until
// the waiting result is taken.
// Reset (i_rst_n low, synchronous) empties the test and drops any result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "separating_axis_overlap_test_assert.svh"

module separating_axis_overlap_test
    import saot_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic signed [COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [COORD_BITS-1:0] i_coord_y,
    input  wire logic signed [COORD_BITS-1:0] i_coord_z,
    input  wire logic                         i_last_axis,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_collide,
    output logic [SEP_W-1:0]                  o_separating_axis,
    output logic [AXC_W-1:0]                  o_axes_tested,
    output logic                              o_corner_overflow
);

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt [2];
    logic [CNT_W-1:0]   n_cnt [2];
    logic               r_ovf, n_ovf;
    logic               r_sep, n_sep;
    logic [SEP_W-1:0]   r_first, n_first;
    logic [AXC_W-1:0]   r_axcnt, n_axcnt;
    logic [SEP_W-1:0]   r_cur, n_cur;
    logic               r_last, n_last;
    logic               r_shape, n_shape;
    logic [CIDX_W-1:0]  r_idx, n_idx;
    logic               r_rd_vld, r_p_vld;
    logic               r_out_vld, n_out_vld;
    logic               r_out_collide, n_out_collide;
    logic [SEP_W-1:0]   r_out_sep, n_out_sep;
    logic [AXC_W-1:0]   r_out_axes, n_out_axes;
    logic               r_out_ovf, n_out_ovf;

    // datapath
    t_corner                   r_mem [2][MAX_CORNERS];
    t_corner                   r_axis;
    t_corner                   r_rd;
    logic                      r_rd_shape, r_rd_first;
    logic                      r_p_shape, r_p_first;
    logic signed [PROD_W-1:0]  r_prod_x, r_prod_y, r_prod_z;
    logic signed [DOT_W-1:0]   r_min [2];
    logic signed [DOT_W-1:0]   r_max [2];

    logic                      accept;
    logic                      wr_en;
    logic                      issue;
    logic                      last_of_shape;
    logic                      drained;
    logic                      sep_now;
    logic                      out_load;
    logic signed [DOT_W-1:0]   dot;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign issue    = (r_state == ST_PROJ);
    assign drained  = !r_rd_vld && !r_p_vld;
    assign sep_now  = (r_max[0] < r_min[1]) || (r_max[1] < r_min[0]);
    assign wr_en    = accept && (i_kind == KIND_CORNER_A || i_kind == KIND_CORNER_B)
                      && (r_cnt[i_kind[0]] < CNT_W'(MAX_CORNERS));
    assign last_of_shape = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt[r_shape];
    assign out_load = (r_state == ST_FIN) && r_last && (!r_out_vld || i_out_ready);
    assign dot      = DOT_W'(r_prod_x) + DOT_W'(r_prod_y) + DOT_W'(r_prod_z);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_ovf         = r_ovf;
        n_sep         = r_sep;
        n_first       = r_first;
        n_axcnt       = r_axcnt;
        n_cur         = r_cur;
        n_last        = r_last;
        n_shape       = r_shape;
        n_idx         = r_idx;
        n_out_vld     = r_out_vld && !i_out_ready;
        n_out_collide = r_out_collide;
        n_out_sep     = r_out_sep;
        n_out_axes    = r_out_axes;
        n_out_ovf     = r_out_ovf;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_CORNER_A, KIND_CORNER_B: begin
                            if (wr_en) begin
                                n_cnt[i_kind[0]] = r_cnt[i_kind[0]] + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_AXIS: begin
                            n_last  = i_last_axis;
                            n_state = ST_FIN;
                            if (r_axcnt < AXC_W'(MAX_AXES)) begin
                                n_axcnt = r_axcnt + AXC_W'(1);
                                n_cur   = r_axcnt[SEP_W-1:0];
                                if (!r_sep) begin
                                    if (r_cnt[0] == '0 || r_cnt[1] == '0) begin
                                        // empty shape separates
                                        n_sep   = 1'b1;
                                        n_first = r_axcnt[SEP_W-1:0];
                                    end else begin
                                        n_state = ST_PROJ;
                                        n_shape = 1'b0;
                                        n_idx   = '0;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROJ: begin
                if (last_of_shape) begin
                    n_idx = '0;
                    if (r_shape) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_shape = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + CIDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    n_state = ST_FIN;
                    if (sep_now) begin
                        n_sep   = 1'b1;
                        n_first = r_cur;
                    end
                end
            end
            ST_FIN: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (out_load) begin
                    n_state       = ST_IDLE;
                    n_out_vld     = 1'b1;
                    n_out_collide = !r_sep;
                    n_out_sep     = r_sep ? r_first : '0;
                    n_out_axes    = r_axcnt;
                    n_out_ovf     = r_ovf;
                    n_cnt[0]      = '0;
                    n_cnt[1]      = '0;
                    n_ovf         = 1'b0;
                    n_sep         = 1'b0;
                    n_first       = '0;
                    n_axcnt       = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt[0]      <= '0;
            r_cnt[1]      <= '0;
            r_ovf         <= 1'b0;
            r_sep         <= 1'b0;
            r_first       <= '0;
            r_axcnt       <= '0;
            r_cur         <= '0;
            r_last        <= 1'b0;
            r_shape       <= 1'b0;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_p_vld       <= 1'b0;
            r_out_vld     <= 1'b0;
            r_out_collide <= 1'b0;
            r_out_sep     <= '0;
            r_out_axes    <= '0;
            r_out_ovf     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_ovf         <= n_ovf;
            r_sep         <= n_sep;
            r_first       <= n_first;
            r_axcnt       <= n_axcnt;
            r_cur         <= n_cur;
            r_last        <= n_last;
            r_shape       <= n_shape;
            r_idx         <= n_idx;
            r_rd_vld      <= issue;
            r_p_vld       <= r_rd_vld;
            r_out_vld     <= n_out_vld;
            r_out_collide <= n_out_collide;
            r_out_sep     <= n_out_sep;
            r_out_axes    <= n_out_axes;
            r_out_ovf     <= n_out_ovf;
        end
    end

    // corner store, axis, and the read / multiply / min-max pipeline
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_kind[0]][r_cnt[i_kind[0]][CIDX_W-1:0]] <= '{i_coord_x, i_coord_y, i_coord_z};
        end
        if (accept && i_kind == KIND_AXIS) begin
            r_axis <= '{i_coord_x, i_coord_y, i_coord_z};
        end
        r_rd       <= r_mem[r_shape][r_idx];
        r_rd_shape <= r_shape;
        r_rd_first <= (r_idx == '0);
        r_prod_x   <= r_rd.x * r_axis.x;
        r_prod_y   <= r_rd.y * r_axis.y;
        r_prod_z   <= r_rd.z * r_axis.z;
        r_p_shape  <= r_rd_shape;
        r_p_first  <= r_rd_first;
        if (r_p_vld) begin
            if (r_p_first || dot < r_min[r_p_shape]) begin
                r_min[r_p_shape] <= dot;
            end
            if (r_p_first || dot > r_max[r_p_shape]) begin
                r_max[r_p_shape] <= dot;
            end
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_vld;
    assign o_collide         = r_out_collide;
    assign o_separating_axis = r_out_sep;
    assign o_axes_tested     = r_out_axes;
    assign o_corner_overflow = r_out_ovf;

    `SAOT_ASSERT_NOW(a_idle_drained, o_in_ready, !r_rd_vld && !r_p_vld, "item taken with projections in flight")
    `SAOT_ASSERT_NEXT(a_result_clears, out_load, r_out_vld && r_axcnt == '0 && !r_sep && !r_ovf, "result load did not clear the test")
    `SAOT_ASSERT_NOW(a_collide_index, o_out_valid && o_collide, o_separating_axis == '0, "colliding result carries an axis index")
    `SAOT_ASSERT_NOW(a_count_bounds, 1'b1, r_axcnt <= AXC_W'(MAX_AXES) && r_cnt[0] <= CNT_W'(MAX_CORNERS) && r_cnt[1] <= CNT_W'(MAX_CORNERS), "count beyond its limit")
    `SAOT_ASSERT_NOW(a_proj_nonempty, r_state == ST_PROJ, r_cnt[0] != '0 && r_cnt[1] != '0 && !r_sep, "projection started without work")

endmodule

`default_nettype wire
